@@ rtl/dtti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_pkg: shared types and constants for the decimal text parser
// Character codes, character classes, the queue item and the queue port
// bundles used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package dtti_pkg;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Result limits
  localparam logic [31:0] RESULT_MIN = 32'h8000_0000;
  localparam logic [31:0] RESULT_MAX = 32'h7FFF_FFFF;

  // Default depth of the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Character class decided in the front end
  typedef enum logic [2:0] {
    KIND_SPACE = 3'd0,
    KIND_MINUS = 3'd1,
    KIND_PLUS  = 3'd2,
    KIND_DIGIT = 3'd3,
    KIND_OTHER = 3'd4
  } char_kind_e;

  // One classified character
  typedef struct packed {
    char_kind_e  kind;
    logic [3:0]  digit;
    logic        last;
  } item_t;

  // Write side of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_wr_t;

  // Read side of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_rd_t;

endpackage

@@ rtl/dtti_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_front: input beat classifier
// Takes one character beat, sorts it into a character class with its digit
// value, and pushes it into the queue when there is room.
// ----------------------------------------------------------------------------
module dtti_front (
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                is_last_i,
  input  logic                queue_full_i,
  output dtti_pkg::queue_wr_t wr_o
);

  logic       is_digit;
  logic [7:0] digit_full;

  // Digit range check and value
  assign is_digit   = (char_code_i >= dtti_pkg::CHAR_ZERO) &&
                      (char_code_i <= dtti_pkg::CHAR_NINE);
  assign digit_full = char_code_i - dtti_pkg::CHAR_ZERO;

  // Classify and push
  always_comb begin
    wr_o.valid      = s_valid_i & ~queue_full_i;
    wr_o.item.digit = digit_full[3:0];
    wr_o.item.last  = is_last_i;
    if (char_code_i == dtti_pkg::CHAR_SPACE) begin
      wr_o.item.kind = dtti_pkg::KIND_SPACE;
    end else if (char_code_i == dtti_pkg::CHAR_MINUS) begin
      wr_o.item.kind = dtti_pkg::KIND_MINUS;
    end else if (char_code_i == dtti_pkg::CHAR_PLUS) begin
      wr_o.item.kind = dtti_pkg::KIND_PLUS;
    end else if (is_digit) begin
      wr_o.item.kind = dtti_pkg::KIND_DIGIT;
    end else begin
      wr_o.item.kind = dtti_pkg::KIND_OTHER;
    end
  end

  // Handshake
  assign s_ready_o   = ~queue_full_i;

endmodule

@@ rtl/dtti_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_queue: short FIFO between front and back end
// Register-based ring buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dtti_queue #(
  parameter int unsigned Depth = dtti_pkg::QUEUE_DEPTH  // at least 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtti_pkg::queue_wr_t wr_i,
  output logic                full_o,
  output dtti_pkg::queue_rd_t rd_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dtti_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign full_o     = (count_q == FullCnt);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.item  = mem_q[rd_ptr_q];

  assign push = wr_i.valid & ~full_o;
  assign pop  = pop_i & rd_o.valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.item;
    end
  end

endmodule

@@ rtl/dtti_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_back: parse state machine and result register
// Pops a classified character per cycle unless stalled, runs the sign/digit FSM
// with a times-ten accumulator, and registers the value on the last character.
// ----------------------------------------------------------------------------
module dtti_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtti_pkg::queue_rd_t rd_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [31:0]         parsed_value_o
);

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic        seen_q, seen_d;
  logic        sat_q, sat_d;
  logic [31:0] nacc_q, nacc_d;   // minus the magnitude
  logic [31:0] mag_q, mag_d;     // magnitude, at most 2^31
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  logic        pop;
  logic        take_digit;
  logic        ovf;
  logic [35:0] nacc_ext;
  logic [35:0] nacc_next;
  logic [35:0] mag_ext;
  logic [35:0] mag_next;
  logic [31:0] final_value;

  // Accept from the queue when the result register can take a beat
  assign pop   = rd_i.valid & (~out_valid_q | m_ready_i);
  assign pop_o = pop;

  // Times ten and add the digit, in both signs
  assign nacc_ext  = {{4{nacc_q[31]}}, nacc_q};
  assign nacc_next = (nacc_ext << 3) + (nacc_ext << 1) - {32'd0, rd_i.item.digit};
  assign mag_ext   = {4'd0, mag_q};
  assign mag_next  = (mag_ext << 3) + (mag_ext << 1) + {32'd0, rd_i.item.digit};
  // Below the 32-bit minimum when the top five bits are not all ones
  assign ovf       = nacc_next[35] & ~(&nacc_next[35:31]);

  // Parse step
  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    seen_d     = seen_q;
    sat_d      = sat_q;
    nacc_d     = nacc_q;
    mag_d      = mag_q;
    take_digit = 1'b0;
    unique case (phase_q)
      PH_SKIP: begin
        unique case (rd_i.item.kind)
          dtti_pkg::KIND_SPACE: phase_d = PH_SKIP;
          dtti_pkg::KIND_MINUS: begin
            neg_d   = 1'b1;
            phase_d = PH_DIGITS;
          end
          dtti_pkg::KIND_PLUS:  phase_d = PH_DIGITS;
          dtti_pkg::KIND_DIGIT: take_digit = 1'b1;
          default:              phase_d = PH_DONE;
        endcase
      end
      PH_DIGITS: begin
        if (rd_i.item.kind == dtti_pkg::KIND_DIGIT) begin
          take_digit = 1'b1;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_DONE;
    endcase
    if (take_digit) begin
      seen_d = 1'b1;
      if (ovf) begin
        sat_d   = 1'b1;
        phase_d = PH_DONE;
      end else begin
        nacc_d  = nacc_next[31:0];
        mag_d   = mag_next[31:0];
        phase_d = PH_DIGITS;
      end
    end
  end

  // Value of the string after this character
  always_comb begin
    if (sat_d) begin
      final_value = neg_d ? dtti_pkg::RESULT_MIN : dtti_pkg::RESULT_MAX;
    end else if (!seen_d) begin
      final_value = '0;
    end else if (neg_d) begin
      final_value = nacc_d;
    end else if (mag_d[31]) begin
      final_value = dtti_pkg::RESULT_MAX;
    end else begin
      final_value = mag_d;
    end
  end

  // Result register
  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    if (pop && rd_i.item.last) begin
      out_valid_d = 1'b1;
      out_data_d  = final_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      sat_q       <= 1'b0;
      nacc_q      <= '0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        if (rd_i.item.last) begin
          // back to the start for the next string
          phase_q <= PH_SKIP;
          neg_q   <= 1'b0;
          seen_q  <= 1'b0;
          sat_q   <= 1'b0;
          nacc_q  <= '0;
          mag_q   <= '0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          seen_q  <= seen_d;
          sat_q   <= sat_d;
          nacc_q  <= nacc_d;
          mag_q   <= mag_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_valid_o      = out_valid_q;
  assign parsed_value_o = out_data_q;

endmodule

@@ rtl/decimal_text_to_int32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_int32: saturating decimal text to signed 32-bit integer
//
//   Channel  Dir  Beat holds                          Beats
//   s_axis   in   one character, tlast on the last    one per character
//   m_axis   out  parsed signed 32-bit value          one per string
//
// One character beat per cycle sustained while no result waits on m_axis_tready;
// m_axis_tvalid rises once a string's last character is taken and has passed
// through the queue and then the result register.
// The times-ten accumulate step in the back end sets the clock path.
// Reset clears the parse state, the queue and the result valid.
// A result waiting on m_axis_tready holds the back end; the queue absorbs up
// to QueueDepth beats before s_axis_tready drops.
// ----------------------------------------------------------------------------
module decimal_text_to_int32 #(
  parameter int unsigned QueueDepth = dtti_pkg::QUEUE_DEPTH  // at least 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] parsed_value
);

  dtti_pkg::queue_wr_t wr;
  dtti_pkg::queue_rd_t rd;
  logic                queue_full;
  logic                pop;

  dtti_front u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .char_code_i  (s_axis_tdata_i),
    .is_last_i    (s_axis_tlast_i),
    .queue_full_i (queue_full),
    .wr_o         (wr)
  );

  dtti_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (queue_full),
    .rd_o   (rd),
    .pop_i  (pop)
  );

  dtti_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_i           (rd),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .parsed_value_o (m_axis_tdata_o)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for decimal_text_to_int32
// Streams character beats into the parser and checks each parsed value
// against an in-bench parser model. The directed strings hit the upper range
// limit, the signs and the malformed cases. The random strings are mostly
// well-formed numbers, plus overflow runs and noise. Both sides stall in
// random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RandomChars = 450;
  localparam int unsigned QuietTail   = 40;    // last beats sent with no idling
  localparam int unsigned StallLimit  = 1000;  // cycles with no beat on either side
  localparam int unsigned MaxReports  = 10;

  // Parser phase as tracked by the model
  typedef enum logic [1:0] {
    SCAN_SPACES = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_ENDED  = 2'd3
  } scan_phase_e;

  // One pending input beat
  typedef struct {
    logic [7:0] code;
    logic       last;
    bit         hold_for_drain;  // wait until every value is back before sending
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;  // [7:0] char_code
  logic        s_axis_tlast_i = 1'b0;  // is_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;  // [31:0] parsed_value

  char_beat_t  char_queue[$];
  logic [31:0] value_queue[$];

  // Model state
  scan_phase_e scan_phase;
  bit          minus_taken;
  bit          digit_taken;
  longint      neg_magnitude;
  bit          clipped;

  // Run bookkeeping
  bit          char_taken;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned idle_cycles;
  int unsigned mismatch_count;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned values_seen;
  int unsigned clipped_values;
  int unsigned zero_values;

  decimal_text_to_int32 u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Model reset
  function automatic void clear_scan();
    scan_phase    = SCAN_SPACES;
    minus_taken   = 1'b0;
    digit_taken   = 1'b0;
    neg_magnitude = 0;
    clipped       = 1'b0;
  endfunction

  // Fold one digit into the negative accumulator, clipping below the 32-bit minimum
  function automatic void fold_digit(input logic [7:0] code);
    longint nxt;
    nxt = neg_magnitude * 10 - longint'(code - dtti_pkg::CHAR_ZERO);
    digit_taken = 1'b1;
    if (nxt < -longint'(64'd2147483648)) begin
      clipped    = 1'b1;
      scan_phase = SCAN_ENDED;
    end else begin
      neg_magnitude = nxt;
      scan_phase    = SCAN_DIGITS;
    end
  endfunction

  // Advance the model by one accepted character; queue a value on the last one
  function automatic void scan_char(input logic [7:0] code, input logic last);
    logic [31:0] value;
    bit          is_num;
    is_num = (code >= dtti_pkg::CHAR_ZERO) && (code <= dtti_pkg::CHAR_NINE);
    case (scan_phase)
      SCAN_SPACES: begin
        if (code == dtti_pkg::CHAR_SPACE) begin
          scan_phase = SCAN_SPACES;
        end else if (code == dtti_pkg::CHAR_MINUS) begin
          minus_taken = 1'b1;
          scan_phase  = SCAN_DIGITS;
        end else if (code == dtti_pkg::CHAR_PLUS) begin
          scan_phase = SCAN_DIGITS;
        end else if (is_num) begin
          fold_digit(code);
        end else begin
          scan_phase = SCAN_ENDED;
        end
      end
      SCAN_DIGITS: begin
        if (is_num) fold_digit(code);
        else scan_phase = SCAN_ENDED;
      end
      default: ;
    endcase
    if (last) begin
      if (clipped) begin
        value = minus_taken ? dtti_pkg::RESULT_MIN : dtti_pkg::RESULT_MAX;
        clipped_values++;
      end else if (!digit_taken) begin
        value = '0;
        zero_values++;
      end else if (minus_taken) begin
        value = neg_magnitude[31:0];
      end else if (neg_magnitude == -longint'(64'd2147483648)) begin
        value = dtti_pkg::RESULT_MAX;
        clipped_values++;
      end else begin
        value = 32'(-neg_magnitude);
      end
      value_queue.push_back(value);
      clear_scan();
    end
  endfunction

  function automatic void push_char(input logic [7:0] code, input logic last,
                                    input bit hold);
    char_beat_t beat;
    beat.code           = code;
    beat.last           = last;
    beat.hold_for_drain = hold;
    char_queue.push_back(beat);
    if (last) strings_sent++;
  endfunction

  function automatic void push_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      push_char(8'(txt[i]), i == txt.len() - 1, 1'b0);
    end
  endfunction

  // One random string: mostly well-formed numbers, some broken, some noise
  function automatic void push_random_string(input bit hold);
    logic [7:0]  txt[$];
    int unsigned pick;
    int unsigned n;
    string       edge_digits;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      n = $urandom_range(0, 3);
      repeat (n) txt.push_back(dtti_pkg::CHAR_SPACE);
      case ($urandom_range(0, 2))
        1: txt.push_back(dtti_pkg::CHAR_MINUS);
        2: txt.push_back(dtti_pkg::CHAR_PLUS);
        default: ;
      endcase
      // broken sign part: second sign or a space after the sign
      if (pick == 7) begin
        case ($urandom_range(0, 2))
          0: txt.push_back(dtti_pkg::CHAR_MINUS);
          1: txt.push_back(dtti_pkg::CHAR_PLUS);
          default: txt.push_back(dtti_pkg::CHAR_SPACE);
        endcase
      end
      case ($urandom_range(0, 5))
        0: begin
          // around the 32-bit limit
          edge_digits = "214748364";
          for (int i = 0; i < edge_digits.len(); i++) txt.push_back(8'(edge_digits[i]));
          txt.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(5, 9)));
          if ($urandom_range(0, 3) == 0) begin
            txt.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          end
        end
        1: begin
          n = $urandom_range(10, 13);
          repeat (n) txt.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        default: begin
          n = $urandom_range(1, 9);
          repeat (n) txt.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) txt.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < txt.size(); i++) begin
      push_char(txt[i], i == txt.size() - 1, hold && (i == 0));
    end
  endfunction

  // Count a mismatch; print only the first few
  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t: %s: expected %0d (0x%08h), got %0d (0x%08h)", $realtime, what,
               $signed(exp_v), exp_v, $signed(act_v), act_v);
    end
  endfunction

  // Stimulus, reset and end of run
  initial begin
    clear_scan();
    // directed strings
    push_text(" +9");
    push_text("-");
    push_char(8'hFF, 1'b1, 1'b0);
    push_text("2147483648");
    push_text("--5");
    push_char(8'h00, 1'b1, 1'b0);
    push_text("12a3");
    // random strings; drain fully before the first and again midway
    push_random_string(1'b1);
    while (char_queue.size() < RandomChars + 25) begin
      push_random_string(char_queue.size() >= 250 && char_queue.size() < 262);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_queue.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (value_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings; checked %0d values", chars_sent,
             strings_sent, values_seen);
    $display("%0d values clipped to the 32-bit limits, %0d with no digits",
             clipped_values, zero_values);
    if (mismatch_count == 0 && value_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d values missing", mismatch_count, value_queue.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Character driver: holds a beat until taken, idles in random bursts
  always @(negedge clk_i) begin : drive_chars
    char_beat_t beat;
    logic       nxt_valid;
    logic [7:0] nxt_code;
    logic       nxt_last;
    nxt_valid = s_axis_tvalid_i;
    nxt_code  = s_axis_tdata_i;
    nxt_last  = s_axis_tlast_i;
    if (rst_ni && (!s_axis_tvalid_i || char_taken)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (char_queue.size() != 0 &&
                   !(char_queue[0].hold_for_drain && value_queue.size() != 0)) begin
        if (char_queue.size() > QuietTail && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
        end else begin
          beat      = char_queue.pop_front();
          nxt_valid = 1'b1;
          nxt_code  = beat.code;
          nxt_last  = beat.last;
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_code;
    s_axis_tlast_i  <= nxt_last;
  end

  // Result sink: ready with random stall bursts, none near the end
  always @(negedge clk_i) begin : drive_ready
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
      end else if (char_queue.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
      end else begin
        nxt_ready = 1'b1;
      end
    end
    m_axis_tready_i <= nxt_ready;
  end

  // Monitor: predict on character beats, check value beats, watchdog
  always @(posedge clk_i) begin : watch_beats
    logic [31:0] exp_v;
    char_taken = 1'b0;
    if (rst_ni) begin
      char_taken = s_axis_tvalid_i && s_axis_tready_o;
      if (char_taken) begin
        chars_sent++;
        scan_char(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        values_seen++;
        if (value_queue.size() == 0) begin
          note_mismatch("value with none expected", 'x, m_axis_tdata_o);
        end else begin
          exp_v = value_queue.pop_front();
          if (m_axis_tdata_o !== exp_v) note_mismatch("parsed value", exp_v, m_axis_tdata_o);
        end
      end
      // watchdog
      if (char_taken || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Timeout: no beat for %0d cycles, %0d values pending", StallLimit,
                   value_queue.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

endmodule
